@@ rtl/lba_pkg.sv @@
// Shared types and codes for the linked block allocator.
`default_nettype none

package lba_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXISTS   = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_COUNT,
        S_LINK,
        S_TAIL,
        S_WSTART,
        S_WALK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic       in_ready;
        logic       latch;
        logic       clr_run;
        logic       scan_start;
        logic       scan_run;
        logic       link_mode;
        logic       tail_write;
        logic       ent_set;
        logic       ent_clr;
        logic       walk_start;
        logic       walk_step;
        logic       set_stat;
        logic [2:0] stat_code;
        logic       res_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic op;
        logic ent_valid;
        logic count_zero;
        logic clr_done;
        logic enough;
        logic scan_end;
        logic taken_all;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/lba_ctrl.sv @@
// Sequencer for the allocator: clearing pass, bitmap scans and chain walk.
`default_nettype none

module lba_ctrl
    import lba_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_sts.in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.op == OP_ALLOC) begin
                    if (i_sts.ent_valid || i_sts.count_zero) n_state = S_RESULT;
                    else                                      n_state = S_COUNT;
                end else begin
                    if (i_sts.ent_valid) n_state = S_WSTART;
                    else                 n_state = S_RESULT;
                end
            end
            S_COUNT: begin
                priority if (i_sts.enough)   n_state = S_LINK;
                else if (i_sts.scan_end)     n_state = S_RESULT;
            end
            S_LINK: begin
                if (i_sts.taken_all) n_state = S_TAIL;
            end
            S_TAIL:   n_state = S_RESULT;
            S_WSTART: n_state = S_WALK;
            S_WALK: begin
                if (i_sts.walk_last) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.stat_code = ST_OK;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_run = 1'b1;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.latch    = i_sts.in_valid;
            end
            S_CHECK: begin
                if (i_sts.op == OP_ALLOC) begin
                    priority if (i_sts.ent_valid) begin
                        o_cmd.set_stat  = 1'b1;
                        o_cmd.stat_code = ST_EXISTS;
                    end else if (i_sts.count_zero) begin
                        o_cmd.set_stat  = 1'b1;
                        o_cmd.stat_code = ST_ZERO;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                    end
                end else if (!i_sts.ent_valid) begin
                    o_cmd.set_stat  = 1'b1;
                    o_cmd.stat_code = ST_NOTFOUND;
                end
            end
            S_COUNT: begin
                priority if (i_sts.enough) begin
                    o_cmd.scan_start = 1'b1;
                end else if (i_sts.scan_end) begin
                    o_cmd.set_stat  = 1'b1;
                    o_cmd.stat_code = ST_NOSPACE;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            S_LINK: begin
                o_cmd.scan_run  = 1'b1;
                o_cmd.link_mode = 1'b1;
            end
            S_TAIL: begin
                o_cmd.tail_write = 1'b1;
                o_cmd.ent_set    = 1'b1;
                o_cmd.set_stat   = 1'b1;
            end
            S_WSTART: o_cmd.walk_start = 1'b1;
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    o_cmd.ent_clr  = 1'b1;
                    o_cmd.set_stat = 1'b1;
                end
            end
            S_RESULT: o_cmd.res_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lba_dp.sv @@
// Datapath: block word memory, file table, scan counters and result register.
`default_nettype none

module lba_dp
    import lba_pkg::*;
#(
    parameter int DISK_BLOCKS = 256,
    parameter int FILE_SLOTS  = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  wire        i_in_valid,
    input  wire        i_op,
    input  wire  [3:0] i_file_id,
    input  wire  [8:0] i_block_count,
    input  wire        i_cfg_valid,
    input  wire  [8:0] i_blocks_in_use,
    input  wire        i_out_stall,
    output logic       o_out_valid,
    output logic [2:0] o_status,
    output logic [7:0] o_start_block
);

    localparam int AW = $clog2(DISK_BLOCKS);
    localparam int CW = $clog2(DISK_BLOCKS + 1);
    localparam int WW = AW + 2;
    localparam int SW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    // word layout: used, last, link
    localparam logic [WW-1:0] CLR_WORD = {1'b0, 1'b1, {AW{1'b0}}};

    logic [WW-1:0] blk_mem [DISK_BLOCKS];
    logic [WW-1:0] r_rdata;
    logic [AW-1:0] ent_start [FILE_SLOTS];
    logic [AW-1:0] r_ent_start;

    logic [FILE_SLOTS-1:0] r_ent_valid;
    logic [8:0]    r_biu;
    logic [CW-1:0] r_ptr;
    logic          r_pend;
    logic [AW-1:0] r_pidx;
    logic [8:0]    r_avail;
    logic [8:0]    r_taken;
    logic [AW-1:0] r_prev;
    logic          r_have_prev;
    logic [AW-1:0] r_start;
    logic [AW-1:0] r_cur;
    logic          r_op;
    logic [3:0]    r_id;
    logic [8:0]    r_count;
    logic [2:0]    r_stat;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [7:0]    r_out_start;

    logic          rd_used;
    logic          rd_last;
    logic [AW-1:0] rd_link;
    logic [CW-1:0] lim;
    logic          in_range;
    logic [SW-1:0] slot;
    logic          id_ok;
    logic          take_free;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [WW-1:0] mem_wd;
    logic [AW-1:0] mem_ra;
    logic          out_free;

    assign rd_used  = r_rdata[WW-1];
    assign rd_last  = r_rdata[WW-2];
    assign rd_link  = r_rdata[AW-1:0];
    assign lim      = (32'(r_biu) > 32'(DISK_BLOCKS)) ? CW'(DISK_BLOCKS) : CW'(r_biu);
    assign in_range = r_ptr < lim;
    assign slot     = SW'(r_id);
    assign id_ok    = 32'(r_id) < 32'(FILE_SLOTS);
    assign take_free = i_cmd.scan_run && r_pend && !rd_used;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts            = '0;
        o_sts.in_valid   = i_in_valid;
        o_sts.op         = r_op;
        // an id beyond the table counts as taken for allocate and absent for free
        o_sts.ent_valid  = id_ok ? r_ent_valid[slot] : (r_op == OP_ALLOC);
        o_sts.count_zero = r_count == 9'd0;
        o_sts.clr_done   = r_ptr == CW'(DISK_BLOCKS - 1);
        o_sts.enough     = r_avail >= r_count;
        o_sts.scan_end   = !r_pend && !in_range;
        o_sts.taken_all  = r_taken == r_count;
        o_sts.walk_last  = rd_last;
        o_sts.out_free   = out_free;
    end

    // write port: one word a cycle, chain link goes into the previous block
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ptr[AW-1:0];
        mem_wd = CLR_WORD;
        priority if (i_cmd.clr_run) begin
            mem_we = 1'b1;
        end else if (take_free && i_cmd.link_mode && (r_taken < r_count) && r_have_prev) begin
            mem_we = 1'b1;
            mem_wa = r_prev;
            mem_wd = {1'b1, 1'b0, r_pidx};
        end else if (i_cmd.tail_write) begin
            mem_we = 1'b1;
            mem_wa = r_prev;
            mem_wd = {1'b1, 1'b1, {AW{1'b0}}};
        end else if (i_cmd.walk_step) begin
            mem_we = 1'b1;
            mem_wa = r_cur;
            mem_wd = CLR_WORD;
        end
    end

    always_comb begin
        priority if (i_cmd.walk_start) mem_ra = r_ent_start;
        else if (i_cmd.walk_step)      mem_ra = rd_link;
        else                           mem_ra = r_ptr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) blk_mem[mem_wa] <= mem_wd;
        r_rdata <= blk_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_set) ent_start[slot] <= r_start;
        r_ent_start <= ent_start[slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu       <= 9'd256;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_ent_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_biu <= i_blocks_in_use;

            priority if (i_cmd.clr_run) begin
                r_ptr <= r_ptr + CW'(1);
            end else if (i_cmd.scan_start) begin
                r_ptr  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_pend <= in_range;
                if (in_range) r_ptr <= r_ptr + CW'(1);
            end

            if (i_cmd.ent_set) r_ent_valid[slot] <= 1'b1;
            if (i_cmd.ent_clr) r_ent_valid[slot] <= 1'b0;

            // hold the result until the far side takes it
            if (i_cmd.res_load)    r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= i_op;
            r_id    <= i_file_id;
            r_count <= i_block_count;
        end
        if (i_cmd.scan_start) begin
            r_avail     <= '0;
            r_taken     <= '0;
            r_have_prev <= 1'b0;
        end else if (take_free) begin
            if (!i_cmd.link_mode) begin
                if (r_avail < r_count) r_avail <= r_avail + 9'd1;
            end else if (r_taken < r_count) begin
                r_taken     <= r_taken + 9'd1;
                r_prev      <= r_pidx;
                r_have_prev <= 1'b1;
                if (!r_have_prev) r_start <= r_pidx;
            end
        end
        if (i_cmd.scan_run) r_pidx <= r_ptr[AW-1:0];
        if (i_cmd.walk_start) r_cur <= r_ent_start;
        else if (i_cmd.walk_step) r_cur <= rd_link;
        if (i_cmd.set_stat) r_stat <= i_cmd.stat_code;
        if (i_cmd.res_load) begin
            r_out_status <= r_stat;
            r_out_start  <= (r_stat == ST_OK && r_op == OP_ALLOC) ? 8'(r_start) : 8'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_start_block = r_out_start;

endmodule

`default_nettype wire

@@ rtl/linked_block_allocator_unit.sv @@
// Top level of the linked block allocator: sequencer plus datapath.
// Allocate: a count scan, then a link scan, over the managed blocks (the lesser of the limit
//   and DISK_BLOCKS); the scans stop early once enough free blocks are seen. Zero size or taken
//   id ends the request without a scan. Output stalls hold the result.
// Free: the chain is walked one block a cycle through the single memory read port.
// One word in flight; a new word is taken while the previous result waits. After reset a
//   clearing pass over all DISK_BLOCKS words runs before the first word is taken.
`default_nettype none

module linked_block_allocator_unit
    import lba_pkg::*;
#(
    parameter int DISK_BLOCKS = 256,
    parameter int FILE_SLOTS  = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_op,
    input  wire  [3:0] i_file_id,
    input  wire  [8:0] i_block_count,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_start_block,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [8:0] i_blocks_in_use
);

    t_cmd cmd;
    t_sts sts;

    lba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lba_dp #(
        .DISK_BLOCKS (DISK_BLOCKS),
        .FILE_SLOTS  (FILE_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_valid      (i_in_valid),
        .i_op            (i_op),
        .i_file_id       (i_file_id),
        .i_block_count   (i_block_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_blocks_in_use (i_blocks_in_use),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_start_block   (o_start_block)
    );

    assign o_in_stall  = !cmd.in_ready;
    assign o_cfg_ready = 1'b1;

    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("word taken straight after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while one is in work");

    a_fail_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_start_block == 8'd0)
        else $error("failed request carries a start block");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_ZERO)
        else $error("status code out of range");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the linked block allocator: queued driver, checking monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lba_pkg::*;

    localparam int DISK_N       = 256;
    localparam int FILE_N       = 16;
    localparam int CHAIN_END    = -1;
    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 600;
    localparam int MAX_REPORTS  = 30;
    localparam int BATCH_WORDS  = 150;

    typedef struct packed {
        logic       op;
        logic [3:0] file_id;
        logic [8:0] block_count;
    } t_request;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] start_block;
    } t_reply;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic       i_op            = OP_ALLOC;
    logic [3:0] i_file_id       = '0;
    logic [8:0] i_block_count   = '0;
    logic       i_out_stall     = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic [8:0] i_blocks_in_use = 9'd256;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_status;
    logic [7:0] o_start_block;
    logic       o_cfg_ready;

    // Allocator shadow: used map, chain links and file table
    bit disk_used [DISK_N];
    int disk_next [DISK_N];
    bit file_live [FILE_N];
    int file_head [FILE_N];
    int limit_cfg = 256;

    t_request queued_requests [$];
    t_reply   pending_replies [$];
    t_request shown_req;
    int       send_wait;
    int       hold_wait;
    int       quiet_cycles;
    int       mismatch_count;
    bit       calm_phase;

    linked_block_allocator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_file_id      (i_file_id),
        .i_block_count  (i_block_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_start_block  (o_start_block),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_blocks_in_use(i_blocks_in_use)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_reply serve_request(t_request req);
        int     lim;
        int     free_seen;
        int     taken;
        int     prev;
        int     cur;
        int     nxt;
        int     steps;
        int     i;
        int     id;
        t_reply rsp;
        rsp.status      = ST_OK;
        rsp.start_block = '0;
        id  = int'(req.file_id);
        lim = (limit_cfg > DISK_N) ? DISK_N : limit_cfg;
        if (req.op == OP_ALLOC) begin
            if (file_live[id]) begin
                rsp.status = ST_EXISTS;
            end else if (req.block_count == 0) begin
                rsp.status = ST_ZERO;
            end else begin
                free_seen = 0;
                for (i = 0; i < lim; i++) begin
                    if (!disk_used[i]) free_seen++;
                end
                if (free_seen < req.block_count) begin
                    rsp.status = ST_NOSPACE;
                end else begin
                    // take the lowest free blocks and link them in ascending order
                    prev  = CHAIN_END;
                    taken = 0;
                    for (i = 0; i < lim && taken < req.block_count; i++) begin
                        if (!disk_used[i]) begin
                            disk_used[i] = 1'b1;
                            disk_next[i] = CHAIN_END;
                            if (prev == CHAIN_END) file_head[id] = i;
                            else disk_next[prev] = i;
                            prev = i;
                            taken++;
                        end
                    end
                    file_live[id]   = 1'b1;
                    rsp.start_block = file_head[id][7:0];
                end
            end
        end else begin
            if (!file_live[id]) begin
                rsp.status = ST_NOTFOUND;
            end else begin
                // walk the whole chain, even past a lowered limit
                cur   = file_head[id];
                steps = 0;
                while (cur >= 0 && cur < DISK_N && steps < DISK_N) begin
                    nxt          = disk_next[cur];
                    disk_used[cur] = 1'b0;
                    disk_next[cur] = CHAIN_END;
                    cur          = nxt;
                    steps++;
                end
                file_live[id] = 1'b0;
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string field, input logic [8:0] want,
                                   input logic [8:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    task automatic queue_request(input logic op, input logic [3:0] id, input logic [8:0] cnt);
        t_request r;
        r.op          = op;
        r.file_id     = id;
        r.block_count = cnt;
        queued_requests = {queued_requests, r};
    endtask

    // Hold the sender until every reply is back, then rewrite the block limit
    task automatic reconfigure(input logic [8:0] value);
        do @(posedge i_clk);
        while (queued_requests.size() != 0 || i_in_valid || pending_replies.size() != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_blocks_in_use <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_cfg = int'(value);
    endtask

    always @(posedge i_clk) begin : drive_requests
        bit took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            took = i_in_valid && !o_in_stall;
            if (took) pending_replies = {pending_replies, serve_request(shown_req)};
            if (!i_in_valid || took) begin
                if (send_wait != 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    shown_req = queued_requests.pop_front();
                    i_in_valid    <= 1'b1;
                    i_op          <= shown_req.op;
                    i_file_id     <= shown_req.file_id;
                    i_block_count <= shown_req.block_count;
                    send_wait = calm_phase ? 0 : $urandom_range(0, 9);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected word, expected none, actual status %0d start %0d",
                                 $time, o_status, o_start_block);
                end else begin
                    want = pending_replies.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 9'(want.status), 9'(o_status));
                    if (o_start_block !== want.start_block)
                        report_mismatch("start_block", 9'(want.start_block),
                                        9'(o_start_block));
                end
                hold_wait = calm_phase ? 0 : $urandom_range(0, 9);
            end else if (hold_wait != 0) begin
                hold_wait--;
            end
            i_out_stall <= (hold_wait != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : run_test
        logic [8:0] random_limits [10];
        bit         gen_live [FILE_N];
        t_request   r;
        int         pick;
        int         base;
        int         k;
        int         p;
        int         n;
        random_limits = '{9'd256, 9'd64, 9'd511, 9'd8, 9'd200,
                          9'd1, 9'd256, 9'd0, 9'd128, 9'd256};
        for (k = 0; k < DISK_N; k++) disk_next[k] = CHAIN_END;
        mismatch_count = 0;
        calm_phase     = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full disk: check order, size extremes, fragmented chains
        reconfigure(9'd256);
        queue_request(OP_ALLOC, 4'd0, 9'd0);
        queue_request(OP_ALLOC, 4'd0, 9'd1);
        queue_request(OP_ALLOC, 4'd0, 9'd0);
        queue_request(OP_ALLOC, 4'd15, 9'd511);
        queue_request(OP_ALLOC, 4'd15, 9'd256);
        queue_request(OP_ALLOC, 4'd1, 9'd3);
        queue_request(OP_ALLOC, 4'd2, 9'd4);
        queue_request(OP_FREE, 4'd1, 9'd511);
        queue_request(OP_FREE, 4'd1, 9'd0);
        queue_request(OP_ALLOC, 4'd3, 9'd6);
        queue_request(OP_ALLOC, 4'd15, 9'd245);
        queue_request(OP_FREE, 4'd3, 9'd0);
        queue_request(OP_FREE, 4'd15, 9'd0);
        queue_request(OP_FREE, 4'd0, 9'd0);
        queue_request(OP_FREE, 4'd2, 9'd0);
        queue_request(OP_ALLOC, 4'd14, 9'd256);
        queue_request(OP_FREE, 4'd14, 9'd0);

        // No managed block at all
        reconfigure(9'd0);
        queue_request(OP_ALLOC, 4'd4, 9'd1);
        queue_request(OP_ALLOC, 4'd4, 9'd0);
        queue_request(OP_FREE, 4'd4, 9'd0);

        // Limit above the disk acts as the whole disk
        reconfigure(9'd511);
        queue_request(OP_ALLOC, 4'd5, 9'd256);
        queue_request(OP_ALLOC, 4'd6, 9'd1);
        queue_request(OP_FREE, 4'd5, 9'd0);
        queue_request(OP_ALLOC, 4'd7, 9'd200);

        // Lowered limit: the long chain must still be freed in full
        reconfigure(9'd16);
        queue_request(OP_ALLOC, 4'd8, 9'd1);
        queue_request(OP_FREE, 4'd7, 9'd0);
        queue_request(OP_ALLOC, 4'd8, 9'd16);
        queue_request(OP_ALLOC, 4'd9, 9'd1);
        queue_request(OP_FREE, 4'd8, 9'd0);

        reconfigure(9'd1);
        queue_request(OP_ALLOC, 4'd10, 9'd1);
        queue_request(OP_ALLOC, 4'd11, 9'd1);
        queue_request(OP_FREE, 4'd10, 9'd0);

        for (k = 0; k < FILE_N; k++) gen_live[k] = 1'b0;
        for (p = 0; p < 10; p++) begin
            reconfigure(random_limits[p]);
            calm_phase = (p % 3 == 2);
            for (n = 0; n < BATCH_WORDS; n++) begin
                pick          = $urandom_range(0, 99);
                r.file_id     = 4'($urandom_range(0, 15));
                r.block_count = 9'($urandom_range(0, 511));
                if (pick < 8) begin
                    r.op = OP_FREE;
                end else if (pick < 14) begin
                    r.op = OP_ALLOC;
                end else begin
                    // mostly free a live file or allocate an unused id
                    r.op = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
                    base = $urandom_range(0, 15);
                    for (k = 0; k < FILE_N; k++) begin
                        r.file_id = 4'(base + k);
                        if (gen_live[r.file_id] == (r.op == OP_FREE)) break;
                    end
                    if (r.op == OP_ALLOC) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 3) r.block_count = 9'd0;
                        else if (pick < 7) r.block_count = 9'($urandom_range(257, 511));
                        else if (pick < 15) r.block_count = 9'($urandom_range(100, 256));
                        else r.block_count = 9'($urandom_range(1, 24));
                        if (r.block_count != 0) gen_live[r.file_id] = 1'b1;
                    end else begin
                        gen_live[r.file_id] = 1'b0;
                    end
                end
                queued_requests = {queued_requests, r};
            end
        end

        do @(posedge i_clk);
        while (queued_requests.size() != 0 || i_in_valid || pending_replies.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lba_pkg.sv
rtl/lba_ctrl.sv
rtl/lba_dp.sv
rtl/linked_block_allocator_unit.sv
dv/tb_top.sv
